// ===== hw/rtl/threshold_dilate_3x3_core_defines.svh =====
// Assertion macros used by the checker of the threshold and dilate block.
// Depends on nothing; the file is guarded against double inclusion.
`ifndef THRESHOLD_DILATE_3X3_CORE_DEFINES_SVH
`define THRESHOLD_DILATE_3X3_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDL_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tdl_pkg.sv =====
// Package of the threshold and dilate block: sizes, codes, payload structs.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
package tdl_pkg;

    // Frame size limits.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Column index, width size, row index and height size widths.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WSZ_W = COL_W + 1;
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int HSZ_W = ROW_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_SIZE_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_THRESHOLD = CFG_IDX_W'(2);
    localparam int CFG_WIDTH_RESET  = 640;
    localparam int CFG_HEIGHT_RESET = 480;
    localparam int CFG_THR_RESET    = 128;

    // Pixel data and the gray conversion.
    localparam int PIX_W       = 8;
    localparam int GRAY_SUM_W  = 16;
    localparam int GRAY_KB     = 30;
    localparam int GRAY_KG     = 150;
    localparam int GRAY_KR     = 76;
    localparam int GRAY_SHIFT  = 8;
    localparam logic [PIX_W-1:0] PIX_BLACK = '0;
    localparam logic [PIX_W-1:0] PIX_WHITE = '1;

    // Request kinds.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Window geometry: three rows per column, two rows kept per line entry.
    localparam int WIN_ROWS = 3;
    localparam int LS_W     = 2;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             last_of_frame;
    } t_out_item;

    // Control and data handed from the front stage to the window stage.
    typedef struct packed {
        logic                pixel;
        logic [PIX_W-1:0]    gray;
        logic [COL_W-1:0]    addr;
        logic                vx_zero;
        logic                emit;
        logic                last;
        logic [WIN_ROWS-1:0] rows;
        logic                left_en;
    } t_stage;

    function automatic logic [WSZ_W-1:0] eff_width(input logic [CFG_SIZE_W-1:0] v);
        logic [WSZ_W-1:0] r;
        if (v == '0) begin
            r = WSZ_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WSZ_W'(MAX_WIDTH);
        end else begin
            r = WSZ_W'(v);
        end
        return r;
    endfunction

    function automatic logic [HSZ_W-1:0] eff_height(input logic [CFG_SIZE_W-1:0] v);
        logic [HSZ_W-1:0] r;
        if (v == '0) begin
            r = HSZ_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HSZ_W'(MAX_HEIGHT);
        end else begin
            r = HSZ_W'(v);
        end
        return r;
    endfunction

    // Row counter that sticks at all ones, which is above any frame height.
    function automatic logic [HSZ_W-1:0] row_sat_inc(input logic [HSZ_W-1:0] r);
        logic [HSZ_W-1:0] n;
        if (&r) begin
            n = r;
        end else begin
            n = r + HSZ_W'(1);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/tdl_cell.sv =====
// One column cell of the 3x3 mark window, three row bits wide.
// Depends on tdl_pkg.
`timescale 1ns / 1ps
module tdl_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic                         i_clear,
    input  logic [tdl_pkg::WIN_ROWS-1:0] i_col,
    input  logic [tdl_pkg::WIN_ROWS-1:0] i_rows,
    input  logic                         i_en,
    output logic [tdl_pkg::WIN_ROWS-1:0] o_col,
    output logic                         o_hit
);
    import tdl_pkg::*;

    logic [WIN_ROWS-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_clear) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    // The cell reports a hit, when enabled, if any of its rows inside the frame is marked.
    assign o_col = r_col;
    assign o_hit = i_en && (|(r_col & i_rows));

endmodule

// ===== hw/rtl/tdl_line_buf.sv =====
// Line buffer holding the marks of the two previous rows for each column.
// Depends on tdl_pkg; one write and one registered read per cycle.
`timescale 1ns / 1ps
module tdl_line_buf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [tdl_pkg::COL_W-1:0] i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [tdl_pkg::COL_W-1:0] i_wr_addr,
    input  logic [tdl_pkg::LS_W-1:0]  i_wr_data,
    output logic [tdl_pkg::LS_W-1:0]  o_rd_data
);
    import tdl_pkg::*;

    logic [LS_W-1:0] mem [MAX_WIDTH];
    logic [LS_W-1:0] r_rd_data;
    logic [LS_W-1:0] r_fwd_data;
    logic            r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // A read that meets a write to the same column in the same cycle takes
    // the new data, which only happens for one-pixel-wide frames.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

// ===== hw/rtl/tdl_ctrl.sv =====
// Front stage: position counters, frame sequencing and gray conversion.
// Depends on tdl_pkg; feeds the line buffer address and the window stage.
`timescale 1ns / 1ps
module tdl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  tdl_pkg::t_in_item         i_item,
    input  logic [tdl_pkg::WSZ_W-1:0] i_width,
    input  logic [tdl_pkg::HSZ_W-1:0] i_height,
    input  logic                      i_advance,
    output logic [tdl_pkg::COL_W-1:0] o_rd_addr,
    output logic                      o_valid,
    output tdl_pkg::t_stage           o_stage
);
    import tdl_pkg::*;

    logic [COL_W-1:0] r_icol;
    logic [HSZ_W-1:0] r_irow;
    logic [COL_W-1:0] r_ox;
    logic [ROW_W-1:0] r_oy;
    logic             r_done;
    logic             r_valid;
    t_stage           r_stage;

    logic [COL_W-1:0]      n_icol;
    logic [HSZ_W-1:0]      n_irow;
    logic [COL_W-1:0]      n_ox;
    logic [ROW_W-1:0]      n_oy;
    logic                  n_done;
    logic                  drain;
    logic                  take;
    logic [COL_W-1:0]      vx;
    logic [HSZ_W-1:0]      vy;
    logic [WSZ_W-1:0]      vx_inc;
    logic [HSZ_W-1:0]      row_nx;
    logic [WSZ_W-1:0]      ox_inc;
    logic [HSZ_W-1:0]      oy_inc;
    logic                  emit;
    logic                  last;
    logic [GRAY_SUM_W-1:0] gray_sum;
    t_stage                stage_nx;

    always_comb begin
        drain = (i_item.operation == OP_DRAIN);
        take  = i_accept && (drain == r_done);

        // A column left past the width by a size change wraps before use.
        if ({1'b0, r_icol} >= i_width) begin
            vx = '0;
            vy = row_sat_inc(r_irow);
        end else begin
            vx = r_icol;
            vy = r_irow;
        end
        vx_inc = {1'b0, vx} + WSZ_W'(1);
        row_nx = row_sat_inc(vy);
        ox_inc = {1'b0, r_ox} + WSZ_W'(1);
        oy_inc = {1'b0, r_oy} + HSZ_W'(1);

        emit = (vy >= HSZ_W'(2)) || ((vy == HSZ_W'(1)) && (vx != '0));
        last = (ox_inc >= i_width) && (oy_inc >= i_height);

        gray_sum = GRAY_SUM_W'(GRAY_KB * int'(i_item.blue))
                 + GRAY_SUM_W'(GRAY_KG * int'(i_item.green))
                 + GRAY_SUM_W'(GRAY_KR * int'(i_item.red));

        stage_nx.pixel   = !drain;
        stage_nx.gray    = PIX_W'(gray_sum >> GRAY_SHIFT);
        stage_nx.addr    = vx;
        stage_nx.vx_zero = (vx == '0);
        stage_nx.emit    = emit;
        stage_nx.last    = emit && last;
        stage_nx.rows    = {oy_inc < i_height, 1'b1, r_oy != '0};
        stage_nx.left_en = (r_ox != '0);

        n_icol = r_icol;
        n_irow = r_irow;
        n_ox   = r_ox;
        n_oy   = r_oy;
        n_done = r_done;
        if (take) begin
            if (vx_inc >= i_width) begin
                n_icol = '0;
                n_irow = row_nx;
                n_done = r_done || (row_nx >= i_height);
            end else begin
                n_icol = vx_inc[COL_W-1:0];
                n_irow = vy;
            end
            if (emit) begin
                if (last) begin
                    n_icol = '0;
                    n_irow = '0;
                    n_ox   = '0;
                    n_oy   = '0;
                    n_done = 1'b0;
                end else if (ox_inc >= i_width) begin
                    n_ox = '0;
                    n_oy = oy_inc[ROW_W-1:0];
                end else begin
                    n_ox = ox_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol  <= '0;
            r_irow  <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_icol <= n_icol;
            r_irow <= n_irow;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_done <= n_done;
            if (i_accept) begin
                r_valid <= take;
            end else if (i_advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_stage <= stage_nx;
        end
    end

    assign o_rd_addr = vx;
    assign o_valid   = r_valid;
    assign o_stage   = r_stage;

endmodule

// ===== hw/rtl/threshold_dilate_3x3_core.sv =====
// Threshold and 3x3 binary dilation of an RGB raster stream, top level.
// A result is registered in the front stage, then in the output register, from the
// request completing its window, width+1 requests after its own pixel. One request
// per cycle unless stalled, as the line buffer reads and writes once per cycle.
// Reset (synchronous, active low) clears counters, window and registers to defaults;
// the line buffer is not cleared, its stale entries are masked at the frame edges.
`timescale 1ns / 1ps
module threshold_dilate_3x3_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tdl_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tdl_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tdl_pkg::*;

    // Configuration. Sizes are held already clamped to the supported range,
    // so the counters compare against them directly.
    logic [WSZ_W-1:0] r_width;
    logic [HSZ_W-1:0] r_height;
    logic [PIX_W-1:0] r_threshold;

    // Output register that decouples the window stage from the consumer.
    logic      r_out_valid;
    t_out_item r_out_item;

    logic                accept;
    logic                advance;
    logic                out_free;
    logic                a_valid;
    t_stage              stage;
    logic [COL_W-1:0]    rd_addr;
    logic [LS_W-1:0]     ls_data;
    logic [LS_W-1:0]     ls_wr_data;
    logic                mark;
    logic [WIN_ROWS-1:0] col;
    logic [WIN_ROWS-1:0] c2_col;
    logic [WIN_ROWS-1:0] c1_col;
    logic                c2_hit;
    logic                c1_hit;
    logic                right_hit;
    logic                hit;

    // The register port is always ready; writes are expected only while idle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WSZ_W'(CFG_WIDTH_RESET);
            r_height    <= HSZ_W'(CFG_HEIGHT_RESET);
            r_threshold <= PIX_W'(CFG_THR_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_width <= eff_width(i_cfg_data);
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= eff_height(i_cfg_data);
                end
                CFG_GRAY_THRESHOLD: begin
                    r_threshold <= i_cfg_data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake. The window stage completes a request whenever it produces
    // no result or the output register can take one. The front stage takes a
    // new request when it is empty or its current request completes, so a
    // stream flows at one request per cycle unless a result waits on a stall.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = a_valid && (!stage.emit || out_free);
    assign o_in_stall = a_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Front stage: positions, frame sequencing, gray value and the line
    // buffer read address. Requests that do not fit the frame phase (pixels
    // during draining, drain ticks before the frame ends) are dropped here.
    tdl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_item),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_advance (advance),
        .o_rd_addr (rd_addr),
        .o_valid   (a_valid),
        .o_stage   (stage)
    );

    // The line buffer is read when a request enters and written when it
    // leaves the window stage; the new entry keeps the row above and the
    // current mark.
    tdl_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (advance),
        .i_wr_addr (stage.addr),
        .i_wr_data (ls_wr_data),
        .o_rd_data (ls_data)
    );

    // Window stage. The new column holds, from bit 0 up, the marks of two
    // rows above, one row above and the current row.
    assign mark       = stage.pixel && (stage.gray > r_threshold);
    assign col        = {mark, ls_data[1], ls_data[0]};
    assign ls_wr_data = {mark, ls_data[1]};

    // Two cells form the chain: the newest stored column is the center of
    // the output pixel and the older one is its left neighbor. The incoming
    // column is the right neighbor, except at the start of a row, where the
    // output pixel sits at the right edge of the previous row.
    tdl_cell u_cell_center (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (advance && !stage.last),
        .i_clear (advance && stage.last),
        .i_col   (col),
        .i_rows  (stage.rows),
        .i_en    (1'b1),
        .o_col   (c2_col),
        .o_hit   (c2_hit)
    );

    tdl_cell u_cell_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (advance && !stage.last),
        .i_clear (advance && stage.last),
        .i_col   (c2_col),
        .i_rows  (stage.rows),
        .i_en    (stage.left_en),
        .o_col   (c1_col),
        .o_hit   (c1_hit)
    );

    assign right_hit = !stage.vx_zero && (|(col & stage.rows));
    assign hit       = c2_hit || c1_hit || right_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && stage.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && stage.emit) begin
            r_out_item.pixel_value   <= hit ? PIX_WHITE : PIX_BLACK;
            r_out_item.last_of_frame <= stage.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The left cell's column leaves the window after this stage.
    logic unused_left;
    assign unused_left = ^c1_col;

endmodule

// ===== hw/rtl/tdl_checker.sv =====
// Port-level checker of the threshold and dilate block, bound to the top level.
// Depends on tdl_pkg and the assertion macros of the block's header.
`timescale 1ns / 1ps
`include "threshold_dilate_3x3_core_defines.svh"
module tdl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input tdl_pkg::t_in_item              i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input tdl_pkg::t_out_item             o_out_item,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [tdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [tdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tdl_pkg::*;

    // A stalled result stays offered and unchanged.
    `TDL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

    // Input back-pressure only comes from a blocked result.
    `TDL_ASSERT_HOLD(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a blocked result")

    // A result rising from idle comes from a request taken via the front stage register.
    `TDL_ASSERT_HOLD(a_out_origin, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2), "result without a matching request")

    // The block only ever produces black or white.
    `TDL_ASSERT_HOLD(a_out_binary, i_clk, i_rst_n, o_out_valid, (o_out_item.pixel_value == PIX_BLACK) || (o_out_item.pixel_value == PIX_WHITE), "result is neither black nor white")

    logic unused_ports;
    assign unused_ports = ^{i_in_item, i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data};

endmodule

bind threshold_dilate_3x3_core tdl_checker u_tdl_checker (.*);
